FILE: design/stip_pkg.sv
// stip_pkg: shared types, constants and character helpers for the
// string-to-integer parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stip_pkg;

    // fixed field widths of the channels
    localparam int CHAR_W   = 8;
    localparam int BASE_W   = 6;
    localparam int VALUE_W  = 64;
    localparam int OFFSET_W = 16;

    // defaults for the top-level parameters
    localparam int DEFAULT_VALUE_BITS = 64;
    localparam int DEFAULT_MAX_LENGTH = 65535;

    // radix codes
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

    // digit value for anything that is not a digit; never below a legal radix
    localparam logic [BASE_W-1:0] NO_DIGIT = 6'd63;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [BASE_W-1:0] d;
        d = NO_DIGIT;
        if (c inside {[CH_ZERO:CH_NINE]})
            d = BASE_W'(c - CH_ZERO);
        else if (c inside {[CH_LA:CH_LZ]})
            d = BASE_W'(c - CH_LA) + BASE_DEC;
        else if (c inside {[CH_UA:CH_UZ]})
            d = BASE_W'(c - CH_UA) + BASE_DEC;
        return d;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic base_ok(input logic [BASE_W-1:0] b);
        return (b == BASE_AUTO) || (b inside {[BASE_MIN:BASE_MAX]});
    endfunction

endpackage

`default_nettype wire

FILE: design/stip_channels.sv
// stip_channels: valid/ready channel interfaces for the parser (characters,
// results, radix writes). Depends on stip_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface stip_char_if import stip_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface stip_result_if import stip_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] end_offset;
    logic                digits_found;

    modport source (output valid, output value, output end_offset, output digits_found,
                    input ready);
    modport sink   (input valid, input value, input end_offset, input digits_found,
                    output ready);
endinterface

interface stip_base_if import stip_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] number_base;

    modport source (output valid, output number_base, input ready);
    modport sink   (input valid, input number_base, output ready);
endinterface

`default_nettype wire

FILE: design/string_to_integer_parser.sv
// string_to_integer_parser: streaming strtol-style parser, one character per transfer.
// Depends on stip_pkg and the interfaces in stip_channels.
//
//  channel   dir   payload                               width
//  text      in    char_code, last                       8, 1
//  result    out   value, end_offset, digits_found       64, 16, 1
//  base_cfg  in    number_base                           6
//
// One character per cycle while text.ready is high: the parse state and the 64x6
// multiply-add of a digit update in the cycle the character transfers.
// A result lands in the output register the cycle after the character that ends
// the number; the sign is applied after that register.
// text.ready drops only while a result is held and result.ready is low.
// Reset returns the parser to whitespace skipping with radix 10; base_cfg is
// always ready.
`timescale 1ns / 1ps
`default_nettype none

module string_to_integer_parser import stip_pkg::*; #(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
    parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    stip_char_if.sink    text,
    stip_result_if.source result,
    stip_base_if.sink    base_cfg
);

    localparam int OFF_BITS = $clog2(MAX_LENGTH + 1);
    localparam int MAC_W    = VALUE_BITS + BASE_W;
    localparam logic [OFF_BITS-1:0] OFF_LIMIT = OFF_BITS'(MAX_LENGTH);

    // radix register
    logic [BASE_W-1:0] number_base_reg;

    // parse state
    phase_t                phase_reg, phase_next;
    logic                  minus_reg, minus_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [OFF_BITS-1:0]   off_reg, off_next;
    logic                  lone_zero_reg, lone_zero_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_mag_reg, out_mag_next;
    logic                  out_minus_reg, out_minus_next;
    logic [OFF_BITS-1:0]   out_off_reg, out_off_next;
    logic                  out_found_reg, out_found_next;

    logic                  accept;
    logic                  emit;
    logic [BASE_W-1:0]     d;
    logic [BASE_W-1:0]     start_base;
    logic [BASE_W-1:0]     eff_base;
    logic [MAC_W-1:0]      mac;
    logic [OFF_BITS-1:0]   off_inc1, off_inc2;
    logic [VALUE_BITS-1:0] signed_mag;

    assign text.ready     = !out_valid_reg || result.ready;
    assign accept         = text.valid && text.ready;
    assign base_cfg.ready = 1'b1;

    assign d        = digit_of(text.char_code);
    assign mac      = MAC_W'(acc_reg) * MAC_W'(base_reg) + MAC_W'(d);
    assign off_inc1 = (off_reg < OFF_LIMIT) ? off_reg + 1'b1 : off_reg;
    assign off_inc2 = (off_inc1 < OFF_LIMIT) ? off_inc1 + 1'b1 : off_inc1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_RESET;
        end
        else if (base_cfg.valid)
        begin
            number_base_reg <= base_cfg.number_base;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        minus_next     = minus_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        off_next       = off_reg;
        lone_zero_next = lone_zero_reg;
        emit           = 1'b0;
        out_mag_next   = out_mag_reg;
        out_minus_next = out_minus_reg;
        out_off_next   = out_off_reg;
        out_found_next = out_found_reg;
        start_base     = (phase_reg == PH_SKIP) ? number_base_reg : base_reg;
        eff_base       = (start_base == BASE_AUTO) ? BASE_DEC : start_base;

        case (phase_reg)
            PH_SKIP, PH_SIGNED:
            begin
                if (phase_reg == PH_SKIP && !base_ok(number_base_reg))
                begin
                    emit           = 1'b1;
                    out_mag_next   = '0;
                    out_minus_next = 1'b0;
                    out_off_next   = '0;
                    out_found_next = 1'b0;
                    phase_next     = PH_DONE;
                end
                else if (phase_reg == PH_SKIP && is_space(text.char_code))
                begin
                    off_next = off_inc1;
                end
                else if (phase_reg == PH_SKIP &&
                         (text.char_code == CH_MINUS || text.char_code == CH_PLUS))
                begin
                    base_next  = number_base_reg;
                    minus_next = (text.char_code == CH_MINUS);
                    phase_next = PH_SIGNED;
                    off_next   = off_inc1;
                end
                else if (text.char_code == CH_ZERO &&
                         (start_base == BASE_AUTO || start_base == BASE_HEX))
                begin
                    base_next      = start_base;
                    phase_next     = PH_ZERO;
                    lone_zero_next = 1'b1;
                    acc_next       = '0;
                    off_next       = off_inc1;
                end
                else
                begin
                    base_next = eff_base;
                    if (d < eff_base)
                    begin
                        acc_next   = VALUE_BITS'(d);
                        phase_next = PH_DIGITS;
                        off_next   = off_inc1;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        out_mag_next   = '0;
                        out_minus_next = 1'b0;
                        out_off_next   = '0;
                        out_found_next = 1'b0;
                        phase_next     = PH_DONE;
                    end
                end
            end
            PH_ZERO:
            begin
                if (text.char_code == CH_LX || text.char_code == CH_UX)
                begin
                    base_next  = BASE_HEX;
                    phase_next = PH_HEXX;   // offset stays on the 'x'
                end
                else
                begin
                    base_next = (base_reg == BASE_AUTO) ? BASE_OCT : base_reg;
                    // accumulator is zero here, so the multiply-add reduces to the digit
                    if (d < base_next)
                    begin
                        acc_next   = VALUE_BITS'(d);
                        phase_next = PH_DIGITS;
                        off_next   = off_inc1;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        out_mag_next   = acc_reg;
                        out_minus_next = minus_reg;
                        out_off_next   = off_reg;
                        out_found_next = 1'b1;
                        phase_next     = PH_DONE;
                    end
                end
            end
            PH_HEXX:
            begin
                if (d < BASE_HEX)
                begin
                    acc_next   = VALUE_BITS'(d);
                    phase_next = PH_DIGITS;
                    off_next   = off_inc2;
                end
                else
                begin
                    emit           = 1'b1;
                    out_mag_next   = '0;
                    out_minus_next = 1'b0;
                    out_off_next   = off_reg;
                    out_found_next = 1'b1;
                    phase_next     = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (d < base_reg)
                begin
                    acc_next = mac[VALUE_BITS-1:0];
                    off_next = off_inc1;
                end
                else
                begin
                    emit           = 1'b1;
                    out_mag_next   = acc_reg;
                    out_minus_next = minus_reg;
                    out_off_next   = off_reg;
                    out_found_next = 1'b1;
                    phase_next     = PH_DONE;
                end
            end
            default:
            begin
                // PH_DONE: rest of the string is dropped
            end
        endcase

        if (text.last)
        begin
            if (!emit)
            begin
                case (phase_next)
                    PH_SKIP, PH_SIGNED:
                    begin
                        emit           = 1'b1;
                        out_mag_next   = '0;
                        out_minus_next = 1'b0;
                        out_off_next   = '0;
                        out_found_next = 1'b0;
                    end
                    PH_ZERO, PH_DIGITS:
                    begin
                        emit           = 1'b1;
                        out_mag_next   = acc_next;
                        out_minus_next = minus_next;
                        out_off_next   = off_next;
                        out_found_next = 1'b1;
                    end
                    PH_HEXX:
                    begin
                        emit           = 1'b1;
                        out_mag_next   = '0;
                        out_minus_next = 1'b0;
                        out_off_next   = off_next;
                        out_found_next = lone_zero_next;
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
            phase_next     = PH_SKIP;
            minus_next     = 1'b0;
            base_next      = BASE_AUTO;
            acc_next       = '0;
            off_next       = '0;
            lone_zero_next = 1'b0;
        end

        if (accept && emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            minus_reg     <= 1'b0;
            base_reg      <= BASE_AUTO;
            acc_reg       <= '0;
            off_reg       <= '0;
            lone_zero_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg     <= phase_next;
                minus_reg     <= minus_next;
                base_reg      <= base_next;
                acc_reg       <= acc_next;
                off_reg       <= off_next;
                lone_zero_reg <= lone_zero_next;
            end
        end
    end

    // payload of the result register, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_mag_reg   <= out_mag_next;
            out_minus_reg <= out_minus_next;
            out_off_reg   <= out_off_next;
            out_found_reg <= out_found_next;
        end
    end

    assign signed_mag          = out_minus_reg ? (~out_mag_reg + 1'b1) : out_mag_reg;
    assign result.valid        = out_valid_reg;
    assign result.value        = VALUE_W'($signed(signed_mag));
    assign result.end_offset   = OFFSET_W'(out_off_reg);
    assign result.digits_found = out_found_reg;

endmodule

`default_nettype wire

FILE: design/stip_checker.sv
// stip_checker: port-level assertions for string_to_integer_parser, bound to
// the top level. Depends on stip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stip_checker import stip_pkg::*; (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                text_valid,
    input wire logic                text_ready,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire logic [VALUE_W-1:0]  value,
    input wire logic [OFFSET_W-1:0] end_offset,
    input wire logic                digits_found
);

    // a stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(value) && $stable(end_offset) && $stable(digits_found)))
        else $error("result changed while stalled");

    // a new result only follows a character transfer
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(text_valid && text_ready))
        else $error("result without a character transfer");

    // with no digits the result is zero at offset zero
    a_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !digits_found) |-> (value == '0 && end_offset == '0))
        else $error("no-digit result carries data");

    // characters are taken whenever no result is held
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> text_ready)
        else $error("text stalled with empty result register");

endmodule

bind string_to_integer_parser stip_checker u_stip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_valid   (text.valid),
    .text_ready   (text.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .value        (result.value),
    .end_offset   (result.end_offset),
    .digits_found (result.digits_found)
);

`default_nettype wire
